@@ sv/cpu_signature_rule_matcher_defines.svh @@
// Assertion macros for the signature rule matcher top module.
// No dependencies; the asserting file includes this header by name.
// Synthesis builds see empty bodies.
`ifndef CPU_SIGNATURE_RULE_MATCHER_DEFINES_SVH
`define CPU_SIGNATURE_RULE_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define CSRM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSRM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSRM_ASSERT(name, prop, msg)
`define CSRM_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ sv/csrm_pkg.sv @@
// Shared types, codes and constants of the signature rule matcher.
// No dependencies; used by every module of the block.
package csrm_pkg;

    localparam int MAX_RULES_DEF = 16;

    localparam logic [95:0] VENDOR_FIRST  = 96'h6c65746e_49656e69_756e6547;
    localparam logic [95:0] VENDOR_SECOND = 96'h444d4163_69746e65_68747541;
    localparam logic [3:0]  FAMILY_EXT_TRIGGER = 4'hf;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_CATCHALL = 2'd1;
    localparam logic [1:0] CMD_LOOKUP   = 2'd2;

    localparam logic [1:0] ST_STORED    = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_LOOKUP    = 2'd3;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_HANDLER  = 2'd1;
    localparam logic [1:0] ACT_SKIP     = 2'd2;
    localparam logic [1:0] ACT_CATCHALL = 2'd3;

    typedef struct packed {
        logic [95:0] vendor;
        logic [8:0]  family_low;
        logic [8:0]  family_high;
        logic [7:0]  model_low;
        logic [7:0]  model_high;
        logic [3:0]  stepping_low;
        logic [3:0]  stepping_high;
        logic        has_handler;
    } rule_t;

    typedef struct packed {
        logic [95:0] vendor;
        logic [8:0]  family;
        logic [7:0]  model;
        logic [3:0]  stepping;
    } key_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

@@ sv/csrm_decode.sv @@
// Decodes the vendor words and the signature word into a lookup key.
// Depends on csrm_pkg.
module csrm_decode
    import csrm_pkg::*;
(
    input  logic [31:0] vendor_word_b,
    input  logic [31:0] vendor_word_d,
    input  logic [31:0] vendor_word_c,
    input  logic [31:0] signature_word,
    output key_t        key
);

    logic [95:0] vendor;
    logic        use_ext;

    assign vendor = {vendor_word_c, vendor_word_d, vendor_word_b};

    // The first vendor always uses the extended fields, the second only
    // when the base family is at its maximum.
    assign use_ext = (vendor == VENDOR_FIRST) ||
                     ((vendor == VENDOR_SECOND) && (signature_word[11:8] == FAMILY_EXT_TRIGGER));

    always_comb
    begin
        key.vendor   = vendor;
        key.stepping = signature_word[3:0];
        if (use_ext)
        begin
            key.family = {5'd0, signature_word[11:8]} + {1'b0, signature_word[27:20]};
            key.model  = {signature_word[19:16], signature_word[7:4]};
        end
        else
        begin
            key.family = {5'd0, signature_word[11:8]};
            key.model  = {4'd0, signature_word[7:4]};
        end
    end

endmodule

@@ sv/csrm_match.sv @@
// Compares one stored rule against a lookup key.
// Depends on csrm_pkg.
module csrm_match
    import csrm_pkg::*;
(
    input  rule_t rule,
    input  key_t  key,
    output logic  hit
);

    logic vendor_eq;
    logic family_ok;
    logic model_ok;
    logic stepping_ok;

    assign vendor_eq   = (rule.vendor == key.vendor);
    assign family_ok   = (key.family >= rule.family_low) && (key.family <= rule.family_high);
    assign model_ok    = (key.model >= rule.model_low) && (key.model <= rule.model_high);
    assign stepping_ok = (key.stepping >= rule.stepping_low) &&
                         (key.stepping <= rule.stepping_high);
    assign hit = vendor_eq && family_ok && model_ok && stepping_ok;

endmodule

@@ sv/csrm_rule_mem.sv @@
// Rule table storage: one write port and one read port with registered data.
// Depends on csrm_pkg.
module csrm_rule_mem
    import csrm_pkg::*;
#(
    parameter int DEPTH = MAX_RULES_DEF,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rule_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output rule_t         rd_data
);

    rule_t mem_reg [DEPTH];
    rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/cpu_signature_rule_matcher.sv @@
// Processor signature rule matcher.
// Command channel: cmd_valid/cmd_stall with command, vendor words, signature
// and rule fields. Result channel: res_valid/res_stall with status, action,
// rule_index and the decoded family, model and stepping.
// An add or catch-all word has its result in the output register in the
// cycle after acceptance. A lookup fetches rule zero at acceptance, then the
// scan compares the stored rules in order until the first hit or until the
// last one misses, and registers the result once the output is free. The scan
// compares one rule per cycle, set by the single read port of the rule memory.
// A lookup with an empty table is loaded like an add, with no scan.
// Command 3 is accepted and produces no result.
// A new command word is accepted once the previous one is finished, and also
// while its result still waits in the output register, provided the receiver
// takes it in the same cycle.
// While the receiver stalls, the result holds and a finished scan waits with it.
// Reset empties the table and clears the catch-all; the rule memory itself
// is not cleared, since only entries below the rule count are ever read.
// Depends on csrm_pkg, csrm_decode, csrm_match, csrm_rule_mem and the
// defines header.
`include "cpu_signature_rule_matcher_defines.svh"

module cpu_signature_rule_matcher
    import csrm_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [31:0] vendor_word_b,
    input  logic [31:0] vendor_word_d,
    input  logic [31:0] vendor_word_c,
    input  logic [31:0] signature_word,
    input  logic [8:0]  family_low,
    input  logic [8:0]  family_high,
    input  logic [7:0]  model_low,
    input  logic [7:0]  model_high,
    input  logic [3:0]  stepping_low,
    input  logic [3:0]  stepping_high,
    input  logic        has_handler,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [1:0]  action,
    output logic [3:0]  rule_index,
    output logic [8:0]  decoded_family,
    output logic [7:0]  decoded_model,
    output logic [3:0]  decoded_stepping
);

    localparam int IDXW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNTW = $clog2(MAX_RULES + 1);

    state_t          state_reg, state_next;
    logic [CNTW-1:0] rule_count_reg, rule_count_next;
    logic            catchall_set_reg, catchall_set_next;
    logic            catchall_handler_reg, catchall_handler_next;
    logic            res_valid_reg, res_valid_next;

    logic [IDXW-1:0] cmp_reg, cmp_next;
    key_t            key_reg, key_next;
    logic [1:0]      status_reg, status_next;
    logic [1:0]      action_reg, action_next;
    logic [3:0]      rule_index_reg, rule_index_next;
    logic [8:0]      family_reg, family_next;
    logic [7:0]      model_reg, model_next;
    logic [3:0]      stepping_reg, stepping_next;

    key_t            key_in;
    rule_t           wr_rule;
    rule_t           rd_rule;
    logic            wr_en;
    logic            rd_en;
    logic [IDXW-1:0] rd_addr;
    logic            hit;
    logic            accept;
    logic            out_free;
    logic            res_load;
    logic            table_full;
    logic [IDXW:0]   cmp_plus;
    logic [IDXW:0]   count_ext;
    logic [IDXW+3:0] cmp_wide;

    csrm_decode u_decode (
        .vendor_word_b  (vendor_word_b),
        .vendor_word_d  (vendor_word_d),
        .vendor_word_c  (vendor_word_c),
        .signature_word (signature_word),
        .key            (key_in)
    );

    csrm_rule_mem #(
        .DEPTH (MAX_RULES),
        .AW    (IDXW)
    ) u_rule_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rule_count_reg[IDXW-1:0]),
        .wr_data (wr_rule),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rule)
    );

    csrm_match u_match (
        .rule (rd_rule),
        .key  (key_reg),
        .hit  (hit)
    );

    assign wr_rule.vendor        = {vendor_word_c, vendor_word_d, vendor_word_b};
    assign wr_rule.family_low    = family_low;
    assign wr_rule.family_high   = family_high;
    assign wr_rule.model_low     = model_low;
    assign wr_rule.model_high    = model_high;
    assign wr_rule.stepping_low  = stepping_low;
    assign wr_rule.stepping_high = stepping_high;
    assign wr_rule.has_handler   = has_handler;

    assign out_free   = !res_valid_reg || !res_stall;
    assign cmd_stall  = !((state_reg == S_IDLE) && out_free);
    assign accept     = cmd_valid && !cmd_stall;
    assign table_full = (rule_count_reg == CNTW'(MAX_RULES));
    assign cmp_plus   = {1'b0, cmp_reg} + (IDXW + 1)'(1);
    assign count_ext  = (IDXW + 1)'(rule_count_reg);
    assign cmp_wide   = {4'd0, cmp_reg};

    always_comb
    begin
        state_next            = state_reg;
        rule_count_next       = rule_count_reg;
        catchall_set_next     = catchall_set_reg;
        catchall_handler_next = catchall_handler_reg;
        cmp_next              = cmp_reg;
        key_next              = key_reg;
        status_next           = status_reg;
        action_next           = action_reg;
        rule_index_next       = rule_index_reg;
        family_next           = family_reg;
        model_next            = model_reg;
        stepping_next         = stepping_reg;
        wr_en                 = 1'b0;
        rd_en                 = 1'b0;
        rd_addr               = '0;
        res_load              = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next     = ST_STORED;
                    action_next     = ACT_NONE;
                    rule_index_next = 4'd0;
                    family_next     = 9'd0;
                    model_next      = 8'd0;
                    stepping_next   = 4'd0;
                    case (command)
                        CMD_ADD:
                        begin
                            res_load = 1'b1;
                            if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                rule_count_next = rule_count_reg + CNTW'(1);
                            end
                        end
                        CMD_CATCHALL:
                        begin
                            res_load = 1'b1;
                            if (catchall_set_reg)
                            begin
                                status_next = ST_DUPLICATE;
                            end
                            else
                            begin
                                catchall_set_next     = 1'b1;
                                catchall_handler_next = has_handler;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            key_next      = key_in;
                            status_next   = ST_LOOKUP;
                            family_next   = key_in.family;
                            model_next    = key_in.model;
                            stepping_next = key_in.stepping;
                            if (rule_count_reg == '0)
                            begin
                                res_load = 1'b1;
                                if (catchall_set_reg && catchall_handler_reg)
                                begin
                                    action_next = ACT_CATCHALL;
                                end
                            end
                            else
                            begin
                                // Fetch rule zero now so the scan compares from the next cycle.
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                cmp_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit || (cmp_plus == count_ext))
                begin
                    // The memory read data holds while the result waits for room.
                    if (out_free)
                    begin
                        res_load        = 1'b1;
                        state_next      = S_IDLE;
                        status_next     = ST_LOOKUP;
                        action_next     = ACT_NONE;
                        rule_index_next = 4'd0;
                        family_next     = key_reg.family;
                        model_next      = key_reg.model;
                        stepping_next   = key_reg.stepping;
                        if (hit)
                        begin
                            action_next     = rd_rule.has_handler ? ACT_HANDLER : ACT_SKIP;
                            rule_index_next = cmp_wide[3:0];
                        end
                        else if (catchall_set_reg && catchall_handler_reg)
                        begin
                            action_next = ACT_CATCHALL;
                        end
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cmp_plus[IDXW-1:0];
                    cmp_next = cmp_plus[IDXW-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            rule_count_reg       <= '0;
            catchall_set_reg     <= 1'b0;
            catchall_handler_reg <= 1'b0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            rule_count_reg       <= rule_count_next;
            catchall_set_reg     <= catchall_set_next;
            catchall_handler_reg <= catchall_handler_next;
            res_valid_reg        <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg <= cmp_next;
        key_reg <= key_next;
        if (res_load)
        begin
            status_reg     <= status_next;
            action_reg     <= action_next;
            rule_index_reg <= rule_index_next;
            family_reg     <= family_next;
            model_reg      <= model_next;
            stepping_reg   <= stepping_next;
        end
    end

    assign res_valid        = res_valid_reg;
    assign status           = status_reg;
    assign action           = action_reg;
    assign rule_index       = rule_index_reg;
    assign decoded_family   = family_reg;
    assign decoded_model    = model_reg;
    assign decoded_stepping = stepping_reg;

    `CSRM_ASSERT(a_count_in_range, rule_count_reg <= CNTW'(MAX_RULES), "rule count beyond table size")
    `CSRM_ASSERT(a_scan_below_count, (state_reg == S_SCAN) |-> (cmp_plus <= count_ext), "scan index beyond rule count")
    `CSRM_ASSERT(a_write_has_room, wr_en |-> ((state_reg == S_IDLE) && !table_full), "rule written into a full table")
    `CSRM_ASSERT(a_catchall_sticky, catchall_set_reg |=> catchall_set_reg, "catch-all flag cleared outside reset")
    `CSRM_ASSERT_ALWAYS(a_reset_no_result, !rst_n |=> !res_valid, "result valid during reset")

endmodule

@@ test/tb_cpu_signature_rule_matcher.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cpu_signature_rule_matcher: a shadow of the rule table
// predicts every reply, random idling and stalling exercise both handshakes.
// Depends on csrm_pkg and the cpu_signature_rule_matcher RTL.
module tb_cpu_signature_rule_matcher
    import csrm_pkg::*;
();

    localparam int          TABLE_DEPTH    = MAX_RULES_DEF;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_OFF       = 200;
    localparam int          PHASE_WORDS    = 485;

    typedef struct {
        logic [1:0]  command;
        rule_t       rule;
        logic [31:0] signature;
    } cmd_word_t;

    typedef struct {
        logic [1:0] status;
        logic [1:0] action;
        logic [3:0] rule_index;
        logic [8:0] family;
        logic [7:0] model;
        logic [3:0] stepping;
    } reply_t;

    class rule_table_shadow;
        rule_t       rules[TABLE_DEPTH];
        int          rule_count;
        bit          catchall_set;
        bit          catchall_handler;
        reply_t      replies_due[$];
        int          mismatches;

        function new();
            rule_count = 0;
            catchall_set = 1'b0;
            catchall_handler = 1'b0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            $display("cpu_signature_rule_matcher mismatch: %s", what);
            mismatches++;
        endtask

        function int pending();
            return replies_due.size();
        endfunction

        // Works out the reply of one accepted command word.
        function void predict_reply(cmd_word_t w);
            reply_t      r;
            logic [31:0] sig;
            logic [8:0]  fam;
            logic [7:0]  mdl;
            logic [3:0]  stp;
            bit          hit;
            r = '{default: '0};
            sig = w.signature;
            hit = 1'b0;
            case (w.command)
                CMD_ADD:
                begin
                    if (rule_count >= TABLE_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        rules[rule_count] = w.rule;
                        rule_count++;
                        r.status = ST_STORED;
                    end
                end
                CMD_CATCHALL:
                begin
                    if (catchall_set)
                    begin
                        r.status = ST_DUPLICATE;
                    end
                    else
                    begin
                        catchall_set = 1'b1;
                        catchall_handler = w.rule.has_handler;
                        r.status = ST_STORED;
                    end
                end
                CMD_LOOKUP:
                begin
                    fam = {5'd0, sig[11:8]};
                    mdl = {4'd0, sig[7:4]};
                    stp = sig[3:0];
                    // The first vendor always takes the extended fields, the second
                    // only when the base family is at its top value.
                    if (w.rule.vendor == VENDOR_FIRST
                        || (w.rule.vendor == VENDOR_SECOND && sig[11:8] == FAMILY_EXT_TRIGGER))
                    begin
                        fam = fam + {1'b0, sig[27:20]};
                        mdl = {sig[19:16], sig[7:4]};
                    end
                    for (int i = 0; i < rule_count && !hit; i++)
                    begin
                        if (rules[i].vendor == w.rule.vendor
                            && fam >= rules[i].family_low && fam <= rules[i].family_high
                            && mdl >= rules[i].model_low && mdl <= rules[i].model_high
                            && stp >= rules[i].stepping_low && stp <= rules[i].stepping_high)
                        begin
                            hit = 1'b1;
                            r.rule_index = 4'(i);
                            r.action = rules[i].has_handler ? ACT_HANDLER : ACT_SKIP;
                        end
                    end
                    if (!hit && catchall_set && catchall_handler)
                        r.action = ACT_CATCHALL;
                    r.status = ST_LOOKUP;
                    r.family = fam;
                    r.model = mdl;
                    r.stepping = stp;
                end
                default:
                    return;
            endcase
            replies_due.insert(replies_due.size(), r);
        endfunction

        task check_reply(reply_t got);
            reply_t exp;
            if (replies_due.size() == 0)
            begin
                report_mismatch("reply arrived with nothing outstanding");
                return;
            end
            exp = replies_due.pop_front();
            if (got.status !== exp.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.action !== exp.action)
                report_mismatch($sformatf("action %0d, expected %0d", got.action, exp.action));
            if (got.rule_index !== exp.rule_index)
                report_mismatch($sformatf("rule_index %0d, expected %0d",
                                          got.rule_index, exp.rule_index));
            if (got.family !== exp.family)
                report_mismatch($sformatf("decoded_family %0d, expected %0d",
                                          got.family, exp.family));
            if (got.model !== exp.model)
                report_mismatch($sformatf("decoded_model %0d, expected %0d",
                                          got.model, exp.model));
            if (got.stepping !== exp.stepping)
                report_mismatch($sformatf("decoded_stepping %0d, expected %0d",
                                          got.stepping, exp.stepping));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  command;
    logic [31:0] vendor_word_b;
    logic [31:0] vendor_word_d;
    logic [31:0] vendor_word_c;
    logic [31:0] signature_word;
    logic [8:0]  family_low;
    logic [8:0]  family_high;
    logic [7:0]  model_low;
    logic [7:0]  model_high;
    logic [3:0]  stepping_low;
    logic [3:0]  stepping_high;
    logic        has_handler;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  status;
    logic [1:0]  action;
    logic [3:0]  rule_index;
    logic [8:0]  decoded_family;
    logic [7:0]  decoded_model;
    logic [3:0]  decoded_stepping;

    rule_table_shadow sb;
    logic [95:0]      other_vendor;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    int               hold_cycles;

    cpu_signature_rule_matcher i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [95:0] pooled_vendor();
        case ($urandom_range(3))
            0: return VENDOR_FIRST;
            1: return VENDOR_SECOND;
            2: return other_vendor;
            default: return '1;
        endcase
    endfunction

    function automatic cmd_word_t make_word(logic [1:0] cmd, rule_t r, logic [31:0] sig);
        cmd_word_t w;
        w.command = cmd;
        w.rule = r;
        w.signature = sig;
        return w;
    endfunction

    function automatic rule_t random_rule();
        rule_t r;
        r.vendor = pooled_vendor();
        r.family_low = 9'($urandom_range(270));
        r.family_high = r.family_low + 9'($urandom_range(60));
        r.model_low = 8'($urandom);
        r.model_high = 8'($urandom_range(255, r.model_low));
        r.stepping_low = 4'($urandom);
        r.stepping_high = 4'($urandom_range(15, r.stepping_low));
        r.has_handler = 1'($urandom_range(1));
        return r;
    endfunction

    // Builds a signature whose decoded fields land inside the ranges of rule r,
    // so that lookups reach rules deep in the table. Unreachable targets simply miss.
    function automatic logic [31:0] aimed_signature(rule_t r);
        int          fam_t;
        int          mdl_t;
        int          base;
        logic [31:0] sig;
        sig = $urandom;
        fam_t = $urandom_range(r.family_low, r.family_high);
        mdl_t = $urandom_range(r.model_low, r.model_high);
        sig[3:0] = 4'($urandom_range(r.stepping_low, r.stepping_high));
        if (r.vendor == VENDOR_FIRST || (r.vendor == VENDOR_SECOND && fam_t >= 15))
        begin
            if (r.vendor == VENDOR_SECOND)
                base = 15;
            else
                base = $urandom_range(fam_t < 15 ? fam_t : 15, fam_t > 255 ? fam_t - 255 : 0);
            sig[11:8] = 4'(base);
            sig[27:20] = 8'(fam_t - base);
            sig[19:16] = 4'(mdl_t >> 4);
            sig[7:4] = 4'(mdl_t);
        end
        else
        begin
            sig[11:8] = 4'(fam_t);
            sig[7:4] = 4'(mdl_t);
        end
        return sig;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t   w;
        int unsigned pick;
        w.rule.vendor = {$urandom, $urandom, $urandom};
        w.rule[42:0] = 43'({$urandom, $urandom});
        w.signature = $urandom;
        pick = $urandom_range(99);
        if (pick < 6)
            w.command = CMD_ADD;
        else if (pick < 9)
            w.command = CMD_CATCHALL;
        else if (pick < 12)
            w.command = CMD_UNUSED;
        else
        begin
            w.command = CMD_LOOKUP;
            pick = $urandom_range(99);
            if (pick < 60 && sb.rule_count > 0)
            begin
                w.rule.vendor = sb.rules[$urandom_range(sb.rule_count - 1)].vendor;
                w.signature = aimed_signature(sb.rules[$urandom_range(sb.rule_count - 1)]);
                if ($urandom_range(1))
                    w.rule.vendor = sb.rules[0].vendor;
            end
            else if (pick < 85)
                w.rule.vendor = pooled_vendor();
            else if (pick < 92)
                w.rule.vendor = pooled_vendor() ^ (96'd1 << $urandom_range(95));
        end
        // Aim some lookups at one specific rule with its own vendor.
        if (w.command == CMD_LOOKUP && pick < 30 && sb.rule_count > 0)
        begin
            pick = $urandom_range(sb.rule_count - 1);
            w.rule.vendor = sb.rules[pick].vendor;
            w.signature = aimed_signature(sb.rules[pick]);
        end
        return w;
    endfunction

    task automatic send_word(cmd_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        command <= w.command;
        vendor_word_b <= w.rule.vendor[31:0];
        vendor_word_d <= w.rule.vendor[63:32];
        vendor_word_c <= w.rule.vendor[95:64];
        signature_word <= w.signature;
        family_low <= w.rule.family_low;
        family_high <= w.rule.family_high;
        model_low <= w.rule.model_low;
        model_high <= w.rule.model_high;
        stepping_low <= w.rule.stepping_low;
        stepping_high <= w.rule.stepping_high;
        has_handler <= w.rule.has_handler;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.predict_reply(w);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        rule_t r;
        bit    ca_handler;
        // Only one catch-all can ever be set in a run; the seed picks its handler.
        ca_handler = 1'($urandom_range(1));
        r = '0;
        send_word(make_word(CMD_LOOKUP, r, 32'h0));
        send_word(make_word(CMD_UNUSED, random_rule(), $urandom));
        r = random_rule();
        r.has_handler = ca_handler;
        send_word(make_word(CMD_CATCHALL, r, $urandom));
        r.has_handler = !ca_handler;
        send_word(make_word(CMD_CATCHALL, r, $urandom));
        r = '0;
        r.vendor = other_vendor;
        send_word(make_word(CMD_LOOKUP, r, $urandom));
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            r = random_rule();
            if (i >= TABLE_DEPTH - 2)
            begin
                // The last two rules take every signature of the two known vendors.
                r.vendor = (i == TABLE_DEPTH - 1) ? VENDOR_FIRST : VENDOR_SECOND;
                r.family_low = '0;
                r.family_high = '1;
                r.model_low = '0;
                r.model_high = '1;
                r.stepping_low = '0;
                r.stepping_high = '1;
            end
            else if (i == 0)
            begin
                r = '{vendor: VENDOR_FIRST, family_low: 9'd270, family_high: 9'd511,
                      model_low: 8'hff, model_high: 8'hff, stepping_low: 4'hf,
                      stepping_high: 4'hf, has_handler: 1'b1};
            end
            else if (i == 1)
            begin
                r = '0;
                r.vendor = '1;
            end
            else if (i == 2)
            begin
                // Empty family range: this rule can never match.
                r.vendor = VENDOR_SECOND;
                r.family_low = 9'd511;
                r.family_high = 9'd0;
            end
            send_word(make_word(CMD_ADD, r, $urandom));
        end
        r = '1;
        send_word(make_word(CMD_ADD, r, 32'hffff_ffff));
        r = '0;
        r.vendor = VENDOR_FIRST;
        send_word(make_word(CMD_LOOKUP, r, 32'hffff_ffff));
        r.vendor = '1;
        send_word(make_word(CMD_LOOKUP, r, 32'h0));
        r.vendor = VENDOR_SECOND;
        send_word(make_word(CMD_LOOKUP, r, 32'h0ff0_0f37));
    endtask

    task automatic run_random(int count);
        cmd_word_t w;
        int        done;
        done = 0;
        while (done < count)
        begin
            w = random_word();
            send_word(w);
            if (w.command != CMD_UNUSED)
                done++;
        end
    endtask

    // Receiver side: a long hold-off when requested, random stalls otherwise.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    initial
    begin
        reply_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                got.status = status;
                got.action = action;
                got.rule_index = rule_index;
                got.family = decoded_family;
                got.model = decoded_model;
                got.stepping = decoded_stepping;
                sb.check_reply(got);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** cpu_signature_rule_matcher: FAILED **");
        $finish;
    end

    initial
    begin
        sb = new();
        other_vendor = {$urandom, $urandom, $urandom};
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        command = CMD_ADD;
        vendor_word_b = '0;
        vendor_word_d = '0;
        vendor_word_c = '0;
        signature_word = '0;
        family_low = '0;
        family_high = '0;
        model_low = '0;
        model_high = '0;
        stepping_low = '0;
        stepping_high = '0;
        has_handler = 1'b0;
        res_stall = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_drained();

        for (int stage = 0; stage < 4; stage++)
        begin
            case (stage)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                    // The receiver holds off while words keep coming, so the block backs up.
                    hold_cycles = HOLD_OFF;
                end
                1:
                begin
                    sender_idle_pct = 71;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 71;
                end
                default:
                begin
                    sender_idle_pct = 21;
                    receiver_stall_pct = 21;
                end
            endcase
            run_random(PHASE_WORDS);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d replies never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("** cpu_signature_rule_matcher: PASSED **");
        else
            $display("** cpu_signature_rule_matcher: FAILED **");
        $finish;
    end

endmodule
